// File: rtl/quaternion_rigid_point_transform_top_macros.svh
// assertion macros for the rigid point transform block
// used by quaternion_rigid_point_transform_top, needs a clock aclk and reset aresetn in scope
`ifndef QUATERNION_RIGID_POINT_TRANSFORM_TOP_MACROS_SVH
`define QUATERNION_RIGID_POINT_TRANSFORM_TOP_MACROS_SVH

// same-cycle implication
`define QRPT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QRPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/qrpt_pkg.sv
// types, constants and helper functions of the rigid point transform
// no dependencies
`default_nettype none

package qrpt_pkg;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_ROT_X   = 3'd0,
        REG_ROT_Y   = 3'd1,
        REG_ROT_Z   = 3'd2,
        REG_ROT_W   = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_SHIFT_Z = 3'd6
    } cfg_index_t;

    localparam int COORD_W = 32;
    localparam int QUAT_W  = 16;
    localparam int CFG_W   = 32;
    localparam int ELEM_W  = 32;   // matrix element, q4.28 with limit +-4.0
    localparam int WIDE_W  = 35;   // element before clamping
    localparam int ACC_W   = 64;   // accumulator, 44 fractional bits
    localparam int FRAC_SHIFT = 28;

    localparam logic signed [QUAT_W-1:0]  ROT_W_RESET = 16'sd16384;
    localparam logic signed [WIDE_W-1:0]  ONE_Q28     = 35'sd268435456;
    localparam logic signed [WIDE_W-1:0]  ELEM_LIMIT  = 35'sd1073741824;
    localparam logic signed [ACC_W-1:0]   HALF_Q28    = 64'sd134217728;
    localparam logic signed [ACC_W-1:0]   COORD_MAX   = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0]   COORD_MIN   = -64'sd2147483648;

    typedef struct packed {
        logic                      clip;
        logic signed [COORD_W-1:0] val;
    } sat_t;

    // clamp a matrix element to [-4.0, +4.0] in q4.28
    function automatic logic signed [ELEM_W-1:0] elem_clamp(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        begin
            if (v > ELEM_LIMIT) begin
                c = ELEM_LIMIT;
            end else if (v < -ELEM_LIMIT) begin
                c = -ELEM_LIMIT;
            end else begin
                c = v;
            end
            elem_clamp = c[ELEM_W-1:0];
        end
    endfunction

    // saturate a rounded value to the 32-bit coordinate range
    function automatic sat_t coord_sat(input logic signed [ACC_W-1:0] v);
        sat_t r;
        begin
            if (v > COORD_MAX) begin
                r.clip = 1'b1;
                r.val  = COORD_MAX[COORD_W-1:0];
            end else if (v < COORD_MIN) begin
                r.clip = 1'b1;
                r.val  = COORD_MIN[COORD_W-1:0];
            end else begin
                r.clip = 1'b0;
                r.val  = v[COORD_W-1:0];
            end
            coord_sat = r;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/quaternion_rigid_point_transform_top.sv
// rigid transform of a 3d point stream: out = R(q) * p + t, q16.16 with saturation
// depends on qrpt_pkg and quaternion_rigid_point_transform_top_macros.svh
//
//  channel  | direction | transaction
//  s_*      | in        | one point, tdata = {point_z, point_y, point_x}
//  m_*      | out       | one result, tdata = {out_z, out_y, out_x}, tuser = clipped
//  cfg_*    | in        | one register write, cfg_index selects, cfg_data carries value
//
// five register stages, one point enters per cycle while s_tready is high, and its result
// is valid on m_* once it has passed through stages 1 to 5 and sits in the output register
// stage 1 quaternion products, 2 matrix elements, 3 nine 32x32 products,
// 4 pair sums, 5 final sum with rounding and saturation (output register)
// each stage takes new data when it is empty or its successor moves, so bubbles close up
// under a stalled m_tready and input keeps flowing until every stage is full
// aresetn is synchronous: valids clear, quaternion returns to identity, translation to zero
`default_nettype none

`include "quaternion_rigid_point_transform_top_macros.svh"

module quaternion_rigid_point_transform_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input point stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,    // point_x [31:0], point_y [63:32], point_z [95:64]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,    // out_x [31:0], out_y [63:32], out_z [95:64]
    output logic [0:0]       m_tuser,    // clipped [0]
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import qrpt_pkg::*;

    // configuration registers
    logic signed [QUAT_W-1:0]  rot_x_reg, rot_y_reg, rot_z_reg, rot_w_reg;
    logic signed [COORD_W-1:0] shift_reg [3];

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic en1, en2, en3, en4, out_en;

    // stage 1: point and quaternion products
    logic signed [COORD_W-1:0] pt1_reg [3];
    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [31:0] wx_reg, wy_reg, wz_reg;

    // stage 2: matrix elements, row major
    logic signed [COORD_W-1:0] pt2_reg [3];
    logic signed [ELEM_W-1:0]  elem_reg [9];
    logic signed [ELEM_W-1:0]  elem_next [9];

    // stage 3: element by coordinate products
    logic signed [ACC_W-1:0] prod_reg [9];

    // stage 4: partial sums per row
    logic signed [ACC_W-1:0] pair_reg [3];
    logic signed [ACC_W-1:0] rest_reg [3];

    // stage 5: output
    logic signed [COORD_W-1:0] out_reg [3];
    logic                      clip_reg;
    sat_t                      sat_next [3];

    // configuration port, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_x_reg    <= '0;
            rot_y_reg    <= '0;
            rot_z_reg    <= '0;
            rot_w_reg    <= ROT_W_RESET;
            shift_reg[0] <= '0;
            shift_reg[1] <= '0;
            shift_reg[2] <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ROT_X:   rot_x_reg    <= cfg_data[QUAT_W-1:0];
                REG_ROT_Y:   rot_y_reg    <= cfg_data[QUAT_W-1:0];
                REG_ROT_Z:   rot_z_reg    <= cfg_data[QUAT_W-1:0];
                REG_ROT_W:   rot_w_reg    <= cfg_data[QUAT_W-1:0];
                REG_SHIFT_X: shift_reg[0] <= cfg_data;
                REG_SHIFT_Y: shift_reg[1] <= cfg_data;
                REG_SHIFT_Z: shift_reg[2] <= cfg_data;
                default: ;   // unused index, write dropped
            endcase
        end
    end

    // per-stage advance: a stage loads when empty or when its contents move on
    assign out_en   = !out_valid_reg || m_tready;
    assign en4      = !v4_reg || out_en;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en1)    v1_reg        <= s_tvalid;
            if (en2)    v2_reg        <= v1_reg;
            if (en3)    v3_reg        <= v2_reg;
            if (en4)    v4_reg        <= v3_reg;
            if (out_en) out_valid_reg <= v4_reg;
        end
    end

    // stage 1: capture point, form the nine quaternion products
    always_ff @(posedge aclk) begin
        if (en1 && s_tvalid) begin
            pt1_reg[0] <= s_tdata[31:0];
            pt1_reg[1] <= s_tdata[63:32];
            pt1_reg[2] <= s_tdata[95:64];
            xx_reg     <= rot_x_reg * rot_x_reg;
            yy_reg     <= rot_y_reg * rot_y_reg;
            zz_reg     <= rot_z_reg * rot_z_reg;
            xy_reg     <= rot_x_reg * rot_y_reg;
            xz_reg     <= rot_x_reg * rot_z_reg;
            yz_reg     <= rot_y_reg * rot_z_reg;
            wx_reg     <= rot_w_reg * rot_x_reg;
            wy_reg     <= rot_w_reg * rot_y_reg;
            wz_reg     <= rot_w_reg * rot_z_reg;
        end
    end

    // stage 2: rotation matrix elements in q4.28, clamped to +-4.0
    always_comb begin
        elem_next[0] = elem_clamp(ONE_Q28 - ((WIDE_W'(yy_reg) + WIDE_W'(zz_reg)) <<< 1));
        elem_next[1] = elem_clamp((WIDE_W'(xy_reg) - WIDE_W'(wz_reg)) <<< 1);
        elem_next[2] = elem_clamp((WIDE_W'(xz_reg) + WIDE_W'(wy_reg)) <<< 1);
        elem_next[3] = elem_clamp((WIDE_W'(xy_reg) + WIDE_W'(wz_reg)) <<< 1);
        elem_next[4] = elem_clamp(ONE_Q28 - ((WIDE_W'(xx_reg) + WIDE_W'(zz_reg)) <<< 1));
        elem_next[5] = elem_clamp((WIDE_W'(yz_reg) - WIDE_W'(wx_reg)) <<< 1);
        elem_next[6] = elem_clamp((WIDE_W'(xz_reg) - WIDE_W'(wy_reg)) <<< 1);
        elem_next[7] = elem_clamp((WIDE_W'(yz_reg) + WIDE_W'(wx_reg)) <<< 1);
        elem_next[8] = elem_clamp(ONE_Q28 - ((WIDE_W'(xx_reg) + WIDE_W'(yy_reg)) <<< 1));
    end

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            pt2_reg <= pt1_reg;
            elem_reg <= elem_next;
        end
    end

    // stage 3: nine signed 32x32 products, 44 fractional bits
    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r*3+c] <= ACC_W'(elem_reg[r*3+c]) * ACC_W'(pt2_reg[c]);
                end
            end
        end
    end

    // stage 4: first two terms, third term plus translation scaled to 44 fractional bits
    always_ff @(posedge aclk) begin
        if (en4 && v3_reg) begin
            for (int r = 0; r < 3; r++) begin
                pair_reg[r] <= prod_reg[r*3] + prod_reg[r*3+1];
                rest_reg[r] <= prod_reg[r*3+2] + (ACC_W'(shift_reg[r]) <<< FRAC_SHIFT);
            end
        end
    end

    // stage 5: round half up to 16 fractional bits, saturate
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sat_next[r] = coord_sat((pair_reg[r] + rest_reg[r] + HALF_Q28) >>> FRAC_SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && v4_reg) begin
            for (int r = 0; r < 3; r++) begin
                out_reg[r] <= sat_next[r].val;
            end
            clip_reg <= sat_next[0].clip | sat_next[1].clip | sat_next[2].clip;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_reg[2], out_reg[1], out_reg[0]};
    assign m_tuser[0] = clip_reg;

    // input only blocks once every stage holds a point and the output is stalled
    `QRPT_ASSERT_SAME(a_stall_only_when_full, !s_tready,
        v1_reg && v2_reg && v3_reg && v4_reg && out_valid_reg && !m_tready,
        "input stalled while the pipeline has a free stage")
    // a clipped result carries a saturation value in some coordinate
    `QRPT_ASSERT_SAME(a_clip_means_limit, m_tvalid && m_tuser[0],
        out_reg[0] == COORD_MAX[COORD_W-1:0] || out_reg[0] == COORD_MIN[COORD_W-1:0] ||
        out_reg[1] == COORD_MAX[COORD_W-1:0] || out_reg[1] == COORD_MIN[COORD_W-1:0] ||
        out_reg[2] == COORD_MAX[COORD_W-1:0] || out_reg[2] == COORD_MIN[COORD_W-1:0],
        "clipped flag set without a saturated coordinate")
    // a held last stage keeps its point while the output is blocked
    `QRPT_ASSERT_NEXT(a_stage4_holds, v4_reg && !out_en, v4_reg,
        "last stage dropped a point during a stall")
    // a new result only comes from a valid last stage
    `QRPT_ASSERT_SAME(a_result_has_source, $rose(m_tvalid), $past(v4_reg),
        "result appeared without a point in the last stage")

endmodule

`default_nettype wire
